// ----- hw/rtl/meot_pkg.sv -----
package meot_pkg;

    // Table and number format
    localparam int VERTEX_DEPTH = 4096;
    localparam int COORD_BITS   = 32;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 12;               // node and link index fields
    localparam int IN_COORD_W   = 32;               // coordinate fields on the port
    localparam int LINK_W       = IDX_W + 1;        // {valid, target}
    localparam int VTX_W        = 3 * COORD_BITS;   // {z, y, x}

    // Arithmetic widths
    localparam int OW    = COORD_BITS + 1;          // operand: point or edge vector
    localparam int MA_W  = OW + 2;                  // first multiplier input
    localparam int PW    = MA_W + OW;               // product
    localparam int CW    = 2 * OW + 1;              // cross product component
    localparam int LO_W  = OW + 1;                  // low slice of a cross component
    localparam int DW    = CW + OW + 2;             // determinant

    // Input word layout, lowest bit first
    localparam int OFF_WIDX = 0;
    localparam int OFF_X    = OFF_WIDX + IDX_W;
    localparam int OFF_Y    = OFF_X + IN_COORD_W;
    localparam int OFF_Z    = OFF_Y + IN_COORD_W;
    localparam int OFF_LINK = OFF_Z + IN_COORD_W;
    localparam int OFF_TGT  = OFF_LINK + 1;
    localparam int OFF_NA   = OFF_TGT + IDX_W;
    localparam int OFF_NB   = OFF_NA + IDX_W;
    localparam int OFF_NC   = OFF_NB + IDX_W;
    localparam int OFF_ND   = OFF_NC + IDX_W;
    localparam int IN_BITS  = OFF_ND + IDX_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Word kinds on s_tuser
    localparam logic [S_TUSER_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [S_TUSER_W-1:0] MODE_TRI   = 2'd1;
    localparam logic [S_TUSER_W-1:0] MODE_TETRA = 2'd2;

    // Result kinds on m_tuser
    localparam logic KIND_TRI   = 1'b0;
    localparam logic KIND_TETRA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PREP,
        ST_MUL,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        MAC_NOP,
        MAC_CROSS_LOAD,
        MAC_CROSS_SUB,
        MAC_DET_LO,
        MAC_DET_HI
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        logic    clear;
    } mac_ctrl_t;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return ({{(32-IDX_W){1'b0}}, idx} < 32'(VERTEX_DEPTH));
    endfunction

endpackage

// ----- hw/rtl/meot_ram.sv -----
module meot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/meot_mac.sv -----
module meot_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  meot_pkg::mac_ctrl_t               ctrl,
    input  logic signed [meot_pkg::OW-1:0]    a_val,
    input  logic signed [meot_pkg::OW-1:0]    b_val,
    output logic                              is_pos
);
    import meot_pkg::*;

    logic signed [MA_W-1:0] ma;
    logic signed [PW-1:0]   prod_reg;
    mac_op_t                op_reg;
    logic signed [CW-1:0]   cross_reg;
    logic signed [DW-1:0]   det_reg;

    // Cross terms take a*b; determinant terms take a slice of the cross
    // component times c, the high slice weighted by 2^LO_W.
    always_comb begin
        case (ctrl.op)
            MAC_DET_LO: ma = {1'b0, cross_reg[LO_W-1:0]};
            MAC_DET_HI: ma = {{2{cross_reg[CW-1]}}, cross_reg[CW-1:LO_W]};
            default:    ma = {{2{a_val[OW-1]}}, a_val};
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * b_val;
        case (op_reg)
            MAC_CROSS_LOAD: cross_reg <= prod_reg[CW-1:0];
            MAC_CROSS_SUB:  cross_reg <= cross_reg - prod_reg[CW-1:0];
            default:        cross_reg <= cross_reg;
        endcase
        if (ctrl.clear) begin
            det_reg <= '0;
        end else begin
            case (op_reg)
                MAC_DET_LO: det_reg <= det_reg + {{(DW-PW){prod_reg[PW-1]}}, prod_reg};
                MAC_DET_HI: det_reg <= det_reg + {prod_reg, {LO_W{1'b0}}};
                default:    det_reg <= det_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= MAC_NOP;
        end else begin
            op_reg <= ctrl.op;
        end
    end

    assign is_pos = !det_reg[DW-1] && (det_reg != '0);

endmodule

// ----- hw/rtl/mesh_element_orientation_test_unit.sv -----
// Channel  | Ports                         | Word contents
// ---------+-------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata     | tuser: mode (0 write, 1 triangle, 2 tetra)
//          | s_tuser                       | tdata: entry write or node indices
// result   | m_tvalid m_tready m_tdata     | tdata: is_positive; tuser: tested_kind
//          | m_tuser                       |
//
// A write word lands in the vertex and link RAMs at once, as soon as it is taken.
// A test goes from acceptance to a loaded result in steps: node fetch, of three
// nodes for a triangle and four for a tetra (link read, then coordinate read, each
// a registered RAM read, overlapped across nodes), one step forms the operands, then
// the single shared 35x33 multiplier runs 12 products, then one drain and one load.
// Reset clears the sequencer and the result valid only; the tables hold garbage
// until written. The result register frees the input side: the block goes back to
// idle and takes the next word while a result waits, and stalls only in the load
// step when a second result finds the register still full.
module mesh_element_orientation_test_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [11:0] write_index, [43:12] coord_x, [75:44] coord_y, [107:76] coord_z,
    // [108] has_link, [120:109] link_target, [132:121] node_a, [144:133] node_b,
    // [156:145] node_c, [168:157] node_d, [175:169] zero
    input  logic [meot_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] mode
    input  logic [meot_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] is_positive, [7:1] zero
    output logic [meot_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] tested_kind
    output logic [meot_pkg::M_TUSER_W-1:0]      m_tuser
);
    import meot_pkg::*;

    state_t state_reg, state_next;

    // Input word fields
    logic [IDX_W-1:0]      in_widx;
    logic [IDX_W-1:0]      in_tgt;
    logic                  in_link;
    logic                  s_accept;
    logic                  tbl_we;

    // Latched test item
    logic                  kind_reg;
    logic [IDX_W-1:0]      nodes_reg [4];

    // Fetch pipeline: stage 1 has the link data, stage 2 the coordinates
    logic [2:0]            fc_reg, fc_next;
    logic [2:0]            n_nodes;
    logic [IDX_W-1:0]      n1_reg;
    logic                  ok1_reg;
    logic                  ok2_reg;
    logic [LINK_W-1:0]     link_rdata;
    logic [VTX_W-1:0]      vtx_rdata;
    logic [IDX_W-1:0]      res_idx;
    logic                  res_ok;
    logic [1:0]            pidx;

    logic signed [COORD_BITS-1:0] p_reg [4][3];
    logic signed [OW-1:0]  a_reg [3];
    logic signed [OW-1:0]  b_reg [3];
    logic signed [OW-1:0]  c_reg [3];

    // Multiply sequence: component k, phase within it
    logic [1:0]            k_reg, k_next;
    logic [2:0]            ph_reg, ph_next;
    logic [1:0]            i1, i2;
    mac_ctrl_t             mac_ctrl;
    logic signed [OW-1:0]  mac_a, mac_b;
    logic                  det_pos;

    logic                  load_out;
    logic                  m_tvalid_reg;
    logic                  m_pos_reg;
    logic                  m_kind_reg;

    assign in_widx  = s_tdata[OFF_WIDX +: IDX_W];
    assign in_tgt   = s_tdata[OFF_TGT +: IDX_W];
    assign in_link  = s_tdata[OFF_LINK];
    assign s_accept = s_tvalid && s_tready;
    assign tbl_we   = s_accept && (s_tuser == MODE_WRITE) && in_range(in_widx);

    meot_ram #(
        .WIDTH (LINK_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (ADDR_W'(in_widx)),
        .wdata ({in_link, in_tgt}),
        .raddr (ADDR_W'(nodes_reg[fc_reg[1:0]])),
        .rdata (link_rdata)
    );

    // Coordinates stored as {z, y, x}, each cut or zero-extended to COORD_BITS
    meot_ram #(
        .WIDTH (VTX_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_vtx_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (ADDR_W'(in_widx)),
        .wdata ({COORD_BITS'(s_tdata[OFF_Z +: IN_COORD_W]),
                 COORD_BITS'(s_tdata[OFF_Y +: IN_COORD_W]),
                 COORD_BITS'(s_tdata[OFF_X +: IN_COORD_W])}),
        .raddr (ADDR_W'(res_idx)),
        .rdata (vtx_rdata)
    );

    // One level of link only; out-of-range node or target gives the origin
    assign res_idx = (ok1_reg && link_rdata[IDX_W]) ? link_rdata[IDX_W-1:0] : n1_reg;
    assign res_ok  = ok1_reg && (!link_rdata[IDX_W] || in_range(link_rdata[IDX_W-1:0]));
    assign n_nodes = (kind_reg == KIND_TETRA) ? 3'd4 : 3'd3;
    assign pidx    = 2'(fc_reg - 3'd2);

    // Cross component k uses a[k+1]*b[k+2] - a[k+2]*b[k+1]
    always_comb begin
        case (k_reg)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        fc_next       = fc_reg;
        k_next        = k_reg;
        ph_next       = ph_reg;
        s_tready      = 1'b0;
        load_out      = 1'b0;
        mac_ctrl.op   = MAC_NOP;
        mac_ctrl.clear = 1'b0;
        mac_a         = a_reg[i1];
        mac_b         = b_reg[i2];
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                fc_next  = 3'd0;
                if (s_tvalid && (s_tuser == MODE_TRI || s_tuser == MODE_TETRA)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                fc_next = fc_reg + 3'd1;
                if (fc_reg == n_nodes + 3'd1) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                mac_ctrl.clear = 1'b1;
                k_next         = 2'd0;
                ph_next        = 3'd0;
                state_next     = ST_MUL;
            end
            ST_MUL: begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0: mac_ctrl.op = MAC_CROSS_LOAD;
                    3'd1: begin
                        mac_ctrl.op = MAC_CROSS_SUB;
                        mac_a       = a_reg[i2];
                        mac_b       = b_reg[i1];
                    end
                    3'd3: begin
                        mac_ctrl.op = MAC_DET_LO;
                        mac_b       = c_reg[k_reg];
                    end
                    3'd4: begin
                        mac_ctrl.op = MAC_DET_HI;
                        mac_b       = c_reg[k_reg];
                        ph_next     = 3'd0;
                        k_next      = k_reg + 2'd1;
                        if (k_reg == 2'd2) begin
                            state_next = ST_DRAIN;
                        end
                    end
                    default: mac_ctrl.op = MAC_NOP;   // cross sum settles
                endcase
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    meot_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a_val   (mac_a),
        .b_val   (mac_b),
        .is_pos  (det_pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fc_reg       <= 3'd0;
            k_reg        <= 2'd0;
            ph_reg       <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_accept) begin
            kind_reg     <= (s_tuser == MODE_TETRA) ? KIND_TETRA : KIND_TRI;
            nodes_reg[0] <= s_tdata[OFF_NA +: IDX_W];
            nodes_reg[1] <= s_tdata[OFF_NB +: IDX_W];
            nodes_reg[2] <= s_tdata[OFF_NC +: IDX_W];
            nodes_reg[3] <= s_tdata[OFF_ND +: IDX_W];
        end
        if (state_reg == ST_FETCH) begin
            n1_reg  <= nodes_reg[fc_reg[1:0]];
            ok1_reg <= in_range(nodes_reg[fc_reg[1:0]]);
            ok2_reg <= res_ok;
            if (fc_reg >= 3'd2) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[pidx][j] <= ok2_reg ? vtx_rdata[j*COORD_BITS +: COORD_BITS] : '0;
                end
            end
        end
        // Triangle: det[p0; p1; p2]. Tetra: same form over edges from p2.
        if (state_reg == ST_PREP) begin
            for (int j = 0; j < 3; j++) begin
                if (kind_reg == KIND_TETRA) begin
                    a_reg[j] <= OW'(p_reg[3][j]) - OW'(p_reg[2][j]);
                    b_reg[j] <= OW'(p_reg[1][j]) - OW'(p_reg[2][j]);
                    c_reg[j] <= OW'(p_reg[0][j]) - OW'(p_reg[2][j]);
                end else begin
                    a_reg[j] <= OW'(p_reg[0][j]);
                    b_reg[j] <= OW'(p_reg[1][j]);
                    c_reg[j] <= OW'(p_reg[2][j]);
                end
            end
        end
        if (load_out) begin
            m_pos_reg  <= det_pos;
            m_kind_reg <= kind_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_pos_reg};
    assign m_tuser  = m_kind_reg;

endmodule

// ----- hw/rtl/meot_checker.sv -----
module meot_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [meot_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [meot_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [meot_pkg::M_TUSER_W-1:0]    m_tuser
);
    import meot_pkg::*;

    // Held result word does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A write word never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_WRITE && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a write word");

    // A test word occupies the block
    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_TRI || s_tuser == MODE_TETRA)
        |=> !s_tready)
        else $error("input still ready after a test word");

    // Padding of the result word stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("result padding not zero");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mesh_element_orientation_test_unit meot_checker u_meot_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/tb_mesh_element_orientation_test_unit.sv -----
`timescale 1ns / 1ps

module tb_mesh_element_orientation_test_unit;
    import meot_pkg::*;

    localparam int CLK_HALF    = 4;          // 8 ns period
    localparam int RESET_LEN   = 11;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 40;

    // mode 3 has no meaning in the block; words carrying it must vanish
    localparam logic [S_TUSER_W-1:0] MODE_UNUSED = 2'd3;

    // one Q24.8 unit
    localparam logic [IN_COORD_W-1:0] Q_ONE   = 32'h0000_0100;
    localparam logic [IN_COORD_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [IN_COORD_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [IN_COORD_W-1:0] Q_M1LSB = 32'hFFFF_FFFF;

    // wide enough for the exact triple product: 32-bit coords -> ~100-bit result
    typedef logic signed [127:0] wide_t;

    // Input word fields, top bit first, so the packed form is the s_tdata layout
    // with write_index in the lowest bits.
    typedef struct packed {
        logic [IDX_W-1:0]      node_d;
        logic [IDX_W-1:0]      node_c;
        logic [IDX_W-1:0]      node_b;
        logic [IDX_W-1:0]      node_a;
        logic [IDX_W-1:0]      link_target;
        logic                  has_link;
        logic [IN_COORD_W-1:0] coord_z;
        logic [IN_COORD_W-1:0] coord_y;
        logic [IN_COORD_W-1:0] coord_x;
        logic [IDX_W-1:0]      write_index;
    } mesh_word_t;

    typedef struct packed {
        logic is_positive;
        logic tested_kind;
    } orient_verdict_t;

    // how coordinates of a freshly written vertex are drawn
    typedef enum int {
        CF_BOX,      // small Q24.8 integers, many flat elements
        CF_TINY,     // a few LSBs only
        CF_FULL,     // any 32-bit pattern
        CF_EXTREME   // range ends and their neighbours
    } coord_flavour_t;

    // ---------------------------------------------------------------- signals
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = MODE_WRITE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    mesh_element_orientation_test_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------- shadow vertex table
    logic [COORD_BITS-1:0] vtx_x   [VERTEX_DEPTH];
    logic [COORD_BITS-1:0] vtx_y   [VERTEX_DEPTH];
    logic [COORD_BITS-1:0] vtx_z   [VERTEX_DEPTH];
    logic                  link_on [VERTEX_DEPTH];
    logic [IDX_W-1:0]      link_to [VERTEX_DEPTH];
    bit                    written [VERTEX_DEPTH];
    int                    written_list [$];   // entries safe to read

    orient_verdict_t verdicts_due [$];         // oldest at the front
    orient_verdict_t due;

    bit          steady_flow = 1'b0;           // both sides idle-free when set
    int unsigned rdy_left    = 0;
    int          rdy_roll;
    int          cycles      = 0;
    int          errors      = 0;
    int          n_writes    = 0;
    int          n_tri       = 0;
    int          n_tetra     = 0;
    int          n_positive  = 0;
    int          n_ignored   = 0;

    // ------------------------------------------------------------- clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results still due", cycles,
                   verdicts_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------ predictor
    // Coordinate of a node after one level of link: a linked entry takes its
    // target's coordinates, whatever the target's own link says.
    function automatic wide_t coord_of(input logic [IDX_W-1:0] node, input int axis);
        int k;
        k = int'(node);
        if (link_on[k])
            k = int'(link_to[k]);
        case (axis)
            0:       return $signed(vtx_x[k]);
            1:       return $signed(vtx_y[k]);
            default: return $signed(vtx_z[k]);
        endcase
    endfunction

    // c . (a x b), exact
    function automatic wide_t triple(input wide_t ax, ay, az, bx, by, bz, cx, cy, cz);
        return cx * (ay * bz - az * by) + cy * (az * bx - ax * bz) + cz * (ax * by - ay * bx);
    endfunction

    // Applies one accepted word to the shadow table, or works out its verdict.
    task automatic note_word(input logic [S_TUSER_W-1:0] mode, input mesh_word_t w);
        int              i;
        int              a;
        wide_t           p [4][3];
        wide_t           det;
        orient_verdict_t v;
        case (mode)
            MODE_WRITE: begin
                i = int'(w.write_index);
                vtx_x[i]   = w.coord_x[COORD_BITS-1:0];
                vtx_y[i]   = w.coord_y[COORD_BITS-1:0];
                vtx_z[i]   = w.coord_z[COORD_BITS-1:0];
                link_on[i] = w.has_link;
                link_to[i] = w.link_target;
                if (!written[i]) begin
                    written[i] = 1'b1;
                    written_list.push_back(i);
                end
                n_writes++;
            end
            MODE_TRI, MODE_TETRA: begin
                for (a = 0; a < 3; a++) begin
                    p[0][a] = coord_of(w.node_a, a);
                    p[1][a] = coord_of(w.node_b, a);
                    p[2][a] = coord_of(w.node_c, a);
                end
                if (mode == MODE_TRI) begin
                    // det[p0; p1; p2] = p2 . (p0 x p1)
                    det = triple(p[0][0], p[0][1], p[0][2], p[1][0], p[1][1], p[1][2],
                                 p[2][0], p[2][1], p[2][2]);
                    v.tested_kind = KIND_TRI;
                    n_tri++;
                end else begin
                    for (a = 0; a < 3; a++)
                        p[3][a] = coord_of(w.node_d, a);
                    // ((p3-p2) x (p1-p2)) . (p0-p2)
                    det = triple(p[3][0] - p[2][0], p[3][1] - p[2][1], p[3][2] - p[2][2],
                                 p[1][0] - p[2][0], p[1][1] - p[2][1], p[1][2] - p[2][2],
                                 p[0][0] - p[2][0], p[0][1] - p[2][1], p[0][2] - p[2][2]);
                    v.tested_kind = KIND_TETRA;
                    n_tetra++;
                end
                v.is_positive = (det > 0);   // flat element gives 0
                if (v.is_positive)
                    n_positive++;
                verdicts_due.push_back(v);
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------ stimulus helpers
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    // a node that is certain to read a written entry once any entry is written
    function automatic logic [IDX_W-1:0] any_node();
        if (written_list.size() == 0)
            return '0;
        return IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    // mostly a small hot set so entries get rewritten and shared
    function automatic int pick_index();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return $urandom_range(0, 31);
        if (roll < 9)
            return $urandom_range(0, VERTEX_DEPTH - 1);
        return $urandom_range(VERTEX_DEPTH - 32, VERTEX_DEPTH - 1);
    endfunction

    function automatic logic [IN_COORD_W-1:0] rand_coord(input coord_flavour_t fl);
        case (fl)
            CF_BOX:  return IN_COORD_W'(($urandom_range(0, 6) - 3) << 8);
            CF_TINY: return IN_COORD_W'($urandom_range(0, 4) - 2);
            CF_FULL: return IN_COORD_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_MIN + 1;
                    3:       return Q_M1LSB;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Random content in every field; node fields still point at written entries
    // in case the block fetches them for a word that does not use them.
    function automatic mesh_word_t noise_word();
        mesh_word_t w;
        w.write_index = IDX_W'($urandom_range(0, VERTEX_DEPTH - 1));
        w.coord_x     = IN_COORD_W'($urandom);
        w.coord_y     = IN_COORD_W'($urandom);
        w.coord_z     = IN_COORD_W'($urandom);
        w.has_link    = 1'($urandom_range(0, 1));
        w.link_target = IDX_W'($urandom_range(0, VERTEX_DEPTH - 1));
        w.node_a      = any_node();
        w.node_b      = any_node();
        w.node_c      = any_node();
        w.node_d      = any_node();
        return w;
    endfunction

    function automatic mesh_word_t fixed_vertex(input int idx,
                                                input logic [IN_COORD_W-1:0] x, y, z,
                                                input logic lnk, input int tgt);
        mesh_word_t w;
        w = noise_word();
        w.write_index = IDX_W'(idx);
        w.coord_x     = x;
        w.coord_y     = y;
        w.coord_z     = z;
        w.has_link    = lnk;
        w.link_target = IDX_W'(tgt);
        return w;
    endfunction

    // Links only ever go to an entry already written (or to the entry itself).
    function automatic mesh_word_t vertex_word(input int idx, input coord_flavour_t fl);
        mesh_word_t w;
        w = fixed_vertex(idx, rand_coord(fl), rand_coord(fl), rand_coord(fl), 1'b0,
                         $urandom_range(0, VERTEX_DEPTH - 1));
        if ($urandom_range(0, 3) == 0) begin
            w.has_link = 1'b1;
            if (written_list.size() == 0 || $urandom_range(0, 4) == 0)
                w.link_target = IDX_W'(idx);
            else
                w.link_target = any_node();
        end
        return w;
    endfunction

    function automatic mesh_word_t element_word(input int na, nb, nc, nd);
        mesh_word_t w;
        w = noise_word();
        w.node_a = IDX_W'(na);
        w.node_b = IDX_W'(nb);
        w.node_c = IDX_W'(nc);
        w.node_d = IDX_W'(nd);
        return w;
    endfunction

    // Presents one word and returns once it is taken. tvalid is only lowered
    // when a gap follows, so a back-to-back word never sees a low/high pair.
    task automatic send_word(input logic [S_TUSER_W-1:0] mode, input mesh_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - IN_BITS){1'b0}}, w};
        do @(posedge aclk); while (!s_tready);
        note_word(mode, w);
    endtask

    // sender stops until every verdict in flight has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    // Four vertices written, then one to three tests on rotations of them.
    // A swap of the first two nodes flips the sign; now and then a node repeats.
    task automatic send_element_burst(output int counted);
        int             idx [4];
        int             k;
        int             r;
        int             tests;
        int             tmp;
        coord_flavour_t fl;
        mesh_word_t     w;
        counted = 0;
        fl = coord_flavour_t'($urandom_range(0, 3));
        for (k = 0; k < 4; k++) begin
            idx[k] = pick_index();
            send_word(MODE_WRITE, vertex_word(idx[k], fl));
            counted++;
        end
        tests = $urandom_range(1, 3);
        for (k = 0; k < tests; k++) begin
            r = $urandom_range(0, 3);
            w = element_word(idx[r], idx[(r + 1) % 4], idx[(r + 2) % 4], idx[(r + 3) % 4]);
            if ($urandom_range(0, 1)) begin
                tmp = int'(w.node_a);
                w.node_a = w.node_b;
                w.node_b = IDX_W'(tmp);
            end
            if ($urandom_range(0, 6) == 0)
                w.node_c = w.node_a;
            send_word($urandom_range(0, 1) ? MODE_TETRA : MODE_TRI, w);
            counted++;
        end
    endtask

    // unrelated single words: writes, tests across the whole table, noise
    task automatic send_loose_item(output int counted);
        int         roll;
        mesh_word_t w;
        roll = $urandom_range(0, 99);
        counted = 1;
        if (roll < 40) begin
            send_word(MODE_WRITE, vertex_word(pick_index(),
                                              coord_flavour_t'($urandom_range(0, 3))));
        end else if (roll < 88) begin
            w = noise_word();
            if ($urandom_range(0, 9) == 0)
                w.node_b = w.node_c;
            send_word($urandom_range(0, 1) ? MODE_TETRA : MODE_TRI, w);
        end else begin
            send_word(MODE_UNUSED, noise_word());
            counted = 0;   // ignored words do not count
        end
    endtask

    task automatic run_random_items(input int n_items);
        int done;
        int got;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 65)
                send_element_burst(got);
            else
                send_loose_item(got);
            done += got;
        end
    endtask

    // ---------------------------------------------------------------- tests
    // Unit axes, range ends, a two-step link chain, a self link, flat elements,
    // both signs of each test and the unused mode.
    task automatic test_directed_cases();
        send_word(MODE_WRITE, fixed_vertex(0, Q_ONE, '0, '0, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(1, '0, Q_ONE, '0, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(2, '0, '0, Q_ONE, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(3, '0, '0, '0, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(4095, Q_MAX, Q_MIN, Q_MAX, 1'b0, 4095));
        send_word(MODE_WRITE, fixed_vertex(4094, Q_MIN, Q_MAX, Q_MAX, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(4093, Q_MAX, Q_MAX, Q_MIN, 1'b0, 0));
        send_word(MODE_WRITE, fixed_vertex(4092, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0));
        // 11 -> 10 -> 0: node 11 must take 10's own coords, not 0's
        send_word(MODE_WRITE, fixed_vertex(10, Q_M1LSB, Q_M1LSB, Q_ONE, 1'b1, 0));
        send_word(MODE_WRITE, fixed_vertex(11, Q_MAX, Q_MAX, Q_MAX, 1'b1, 10));
        send_word(MODE_WRITE, fixed_vertex(12, Q_ONE, Q_ONE, Q_MIN, 1'b1, 12));

        send_word(MODE_TRI, element_word(0, 1, 2, 3));          // positive
        send_word(MODE_TRI, element_word(1, 0, 2, 3));          // negative
        send_word(MODE_TRI, element_word(0, 0, 1, 2));          // flat
        send_word(MODE_TRI, element_word(4095, 4094, 4093, 0));
        send_word(MODE_TRI, element_word(11, 1, 2, 0));
        send_word(MODE_TRI, element_word(10, 1, 2, 0));
        send_word(MODE_TRI, element_word(12, 4092, 3, 0));
        send_word(MODE_TETRA, element_word(3, 0, 1, 2));        // negative
        send_word(MODE_TETRA, element_word(0, 3, 1, 2));        // positive
        send_word(MODE_TETRA, element_word(0, 1, 2, 0));        // flat
        send_word(MODE_TETRA, element_word(4092, 4095, 4094, 4093));
        send_word(MODE_UNUSED, noise_word());
        send_word(MODE_TETRA, element_word(11, 10, 12, 4095));
        hold_until_drained();
    endtask

    // no gaps on either side: back-to-back words and a sink that never stalls
    task automatic test_streaming_no_gaps();
        steady_flow <= 1'b1;
        run_random_items(250);
        steady_flow <= 1'b0;
    endtask

    task automatic test_random_mesh();
        run_random_items(1300);
    endtask

    // short bursts, each followed by a full drain of the result path
    task automatic test_drain_pause();
        repeat (8) begin
            run_random_items(25);
            hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------ result sink
    // Runs of ready and of stall: stalls mostly short, a few long.
    always @(posedge aclk) begin
        if (steady_flow) begin
            m_tready <= 1'b1;
            rdy_left <= 0;
        end else if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 60) begin
                m_tready <= 1'b1;
                rdy_left <= $urandom_range(0, 8);
            end else if (rdy_roll < 93) begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(15, 60);
            end
        end
    end

    // each result word against the oldest verdict waiting
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result word with nothing due: is_positive=%0b tested_kind=%0b",
                       m_tdata[0], m_tuser[0]);
                errors++;
            end else begin
                due = verdicts_due.pop_front();
                if (m_tdata[0] !== due.is_positive) begin
                    $error("is_positive: expected %0b, got %0b", due.is_positive, m_tdata[0]);
                    errors++;
                end
                if (m_tuser[0] !== due.tested_kind) begin
                    $error("tested_kind: expected %0b, got %0b", due.tested_kind, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_streaming_no_gaps();
        test_random_mesh();
        test_drain_pause();

        // all words taken; wait out the verdicts, then a quiet tail for strays
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d vertex writes, %0d triangle and %0d tetra tests, %0d positive.",
                 n_writes, n_tri, n_tetra, n_positive);
        $display("%0d unused-mode words ignored; %0d mismatches over %0d cycles.",
                 n_ignored, errors, cycles);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
